// ===== sv/sip_pkg.sv =====
package sip_pkg;

  localparam int ID_W      = 16;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int FRESH_W   = ID_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ID_W;
  localparam int DEPTH_DEF = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_idx_t;

  // Per-beat decision handed from the control stage to the result stage
  typedef struct packed {
    logic            from_mem;
    logic [ID_W-1:0] fresh_id;
    st_t             status;
  } dec_t;

endpackage

// ===== sv/sip_if.sv =====
interface sip_in_if;
  logic                     valid;
  logic                     ready;
  logic [sip_pkg::OP_W-1:0] opcode;
  logic [sip_pkg::ID_W-1:0] id_value;

  modport source (output valid, output opcode, output id_value, input ready);
  modport sink   (input valid, input opcode, input id_value, output ready);
endinterface

interface sip_out_if;
  logic                     valid;
  logic                     ready;
  logic [sip_pkg::ID_W-1:0] id_out;
  logic [sip_pkg::ST_W-1:0] status;

  modport source (output valid, output id_out, output status, input ready);
  modport sink   (input valid, input id_out, input status, output ready);
endinterface

// ===== sv/session_id_pool_top.sv =====
// FIFO pool of 16-bit session IDs. Opcode 0 (init) empties the pool and loads
// start_id..end_id, 1 (alloc) returns an unused range ID, else the oldest freed
// ID, 2 (free) queues an in-range ID for reuse; every beat yields exactly one
// result. One beat is accepted per clock while the output is not stalled; the
// result register is loaded from a stage that holds the decision beside the
// registered read of the freed-ID store (one write and one read port, DEPTH
// entries). Unused range IDs are counted, not stored, so init writes no store
// entries and the store needs no clearing pass after reset.
// Registers should be written only while no beat is in flight.
module session_id_pool_top #(
  parameter int DEPTH = sip_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sip_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sip_pkg::CFG_W-1:0]     cfg_data,
  sip_in_if.sink                        in_ch,
  sip_out_if.source                     out_ch
);
  import sip_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic            fire;
  logic            s1_ready, s1_valid;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ID_W-1:0] mem_wdata, rd_data;
  dec_t            dec;

  assign in_ch.ready = s1_ready;
  assign fire        = in_ch.valid && s1_ready;

  sip_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .opcode    (in_ch.opcode),
    .id_value  (in_ch.id_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .dec       (dec)
  );

  sip_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (fire),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  sip_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .dec      (dec),
    .rd_data  (rd_data),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .out_ch   (out_ch)
  );

  a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> s1_valid)
    else $error("accepted beat did not reach the result stage");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid)
    else $error("input stalled with an empty result stage");

  a_err_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.id_out == '0))
    else $error("non-zero ID on an error result");

endmodule

// ===== sv/sip_store.sv =====
module sip_store #(
  parameter int DEPTH = sip_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [sip_pkg::ID_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [sip_pkg::ID_W-1:0] rd_data
);
  import sip_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no beat is taken
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/sip_ctrl.sv =====
module sip_ctrl #(
  parameter int DEPTH = sip_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sip_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sip_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          fire,
  input  logic [sip_pkg::OP_W-1:0]      opcode,
  input  logic [sip_pkg::ID_W-1:0]      id_value,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [sip_pkg::ID_W-1:0]      mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  output sip_pkg::dec_t                 dec
);
  import sip_pkg::*;

  logic [ID_W-1:0]    start_r, end_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [FRESH_W-1:0] fresh_r, fresh_nxt;
  logic [FRESH_W-1:0] left_r, left_nxt;
  op_t                op;
  logic               in_range;

  assign op       = op_t'(opcode);
  assign in_range = (id_value >= start_r) && (id_value <= end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_START: start_r <= cfg_data;
        CFG_END:   end_r   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    left_nxt  = left_r;
    mem_we    = 1'b0;
    dec       = '{from_mem: 1'b0, fresh_id: '0, status: ST_OK};
    if (fire) begin
      unique case (op)
        OP_INIT: begin
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt  = '0;
          if (start_r <= end_r) begin
            fresh_nxt = {1'b0, start_r};
            left_nxt  = {1'b0, end_r} - {1'b0, start_r} + FRESH_W'(1);
          end else begin
            fresh_nxt = '0;
            left_nxt  = '0;
          end
        end
        OP_ALLOC: begin
          // untouched range IDs go out before anything freed
          if (left_r != '0) begin
            dec.fresh_id = fresh_r[ID_W-1:0];
            fresh_nxt    = fresh_r + FRESH_W'(1);
            left_nxt     = left_r - FRESH_W'(1);
          end else if (cnt_r != '0) begin
            dec.from_mem = 1'b1;
            head_nxt     = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
            cnt_nxt      = cnt_r - CW'(1);
          end else begin
            dec.status = ST_EMPTY;
          end
        end
        OP_FREE: begin
          if (!in_range) begin
            dec.status = ST_RANGE;
          end else if (cnt_r == CW'(DEPTH)) begin
            dec.status = ST_FULL;
          end else begin
            mem_we   = 1'b1;
            tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      fresh_r <= '0;
      left_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
      left_r  <= left_nxt;
    end
  end

  assign mem_waddr = tail_r;
  assign mem_wdata = id_value;
  assign mem_raddr = head_r;

endmodule

// ===== sv/sip_outreg.sv =====
module sip_outreg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  sip_pkg::dec_t            dec,
  input  logic [sip_pkg::ID_W-1:0] rd_data,
  output logic                     s1_ready,
  output logic                     s1_valid,
  sip_out_if.source                out_ch
);
  import sip_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  dec_t            s1_dec_r;
  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_id_r;
  st_t             out_st_r;
  logic            out_space;
  logic            s1_move;

  assign out_space    = !out_valid_r || out_ch.ready;
  assign s1_move      = s1_valid_r && out_space;
  assign s1_ready     = !s1_valid_r || out_space;
  assign s1_valid_nxt = fire || (s1_valid_r && !out_space);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_dec_r <= dec;
    end
    if (s1_move) begin
      out_id_r <= s1_dec_r.from_mem ? rd_data : s1_dec_r.fresh_id;
      out_st_r <= s1_dec_r.status;
    end
  end

  assign s1_valid      = s1_valid_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.id_out = out_id_r;
  assign out_ch.status = out_st_r;

endmodule
